>>> hdl/stt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Search transposition table package
// Shared types, constants and codes for the transposition table block.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned INDEX_BITS_DEF = 12;
  localparam int unsigned GEN_BITS_DEF   = 6;

  localparam int unsigned KEY_W      = 64;
  localparam int unsigned SCORE_W    = 16;
  localparam int unsigned MOVE_W     = 16;
  localparam int unsigned DEPTH_W    = 8;
  localparam int unsigned PLY_W      = 8;
  localparam int unsigned BTYPE_W    = 2;
  localparam int unsigned THRESH_W   = 15;
  localparam int unsigned CUR_GEN_W  = 6;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [THRESH_W-1:0]  THRESH_RST  = 15'd30000;
  localparam logic [CUR_GEN_W-1:0] CUR_GEN_RST = '0;

  localparam logic [CFG_IDX_W-1:0] CFG_MATE_THRESHOLD     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_GENERATION = 8'd1;

  localparam logic ACT_PROBE = 1'b0;
  localparam logic ACT_STORE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_EXEC
  } stt_state_e;

  typedef struct packed {
    logic                      action;
    logic [KEY_W-1:0]          key;
    logic [PLY_W-1:0]          ply;
    logic [DEPTH_W-1:0]        depth;
    logic [MOVE_W-1:0]         best_move;
    logic signed [SCORE_W-1:0] score;
    logic [BTYPE_W-1:0]        bound_type;
  } stt_req_t;

  typedef struct packed {
    logic                      hit;
    logic                      written;
    logic signed [SCORE_W-1:0] found_score;
    logic [DEPTH_W-1:0]        found_depth;
    logic [MOVE_W-1:0]         found_move;
    logic [BTYPE_W-1:0]        found_type;
  } stt_rsp_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic clr_en;
  } stt_ctrl_t;

  typedef struct packed {
    logic clr_last;
  } stt_status_t;

endpackage

>>> hdl/stt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/stt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transposition table controller
// Sequences the clearing pass after reset and the read and execute steps.
// ----------------------------------------------------------------------------
module stt_ctrl
  import stt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  stt_status_t status_i,
  output stt_ctrl_t   ctrl_o
);

  stt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_CLEAR: begin
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy          = 1'b1;
    ctrl_o.accept = 1'b0;
    ctrl_o.exec   = 1'b0;
    ctrl_o.clr_en = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy          = 1'b0;
        ctrl_o.accept = start;
      end
      ST_CLEAR: begin
        ctrl_o.clr_en = 1'b1;
      end
      ST_EXEC: begin
        ctrl_o.exec = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.accept |=> state_q == ST_EXEC)
    else $error("Accepted beat did not move to execute.");

  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.clr_en && status_i.clr_last) |=> state_q == ST_IDLE)
    else $error("Clearing pass did not end in idle.");

  a_no_accept_while_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.clr_en |-> !ctrl_o.accept && !ctrl_o.exec)
    else $error("Command issued during clearing pass.");
`endif

endmodule

>>> hdl/stt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transposition table datapath
// Entry memory, configuration registers, probe and store logic, result register.
// ----------------------------------------------------------------------------
module stt_datapath
  import stt_pkg::*;
#(
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF,
  parameter int unsigned GEN_BITS   = GEN_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stt_ctrl_t             ctrl_i,
  output stt_status_t           status_o,
  input  stt_req_t              req_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output stt_rsp_t              rsp_o
);

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    logic [MOVE_W-1:0]  move;
    logic [DEPTH_W-1:0] depth;
    logic [BTYPE_W-1:0] btype;
    logic [GEN_BITS-1:0] gen;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);
  localparam int unsigned Depth  = 2 ** INDEX_BITS;

  function automatic logic [SCORE_W-1:0] mate_adjust(
    input logic [SCORE_W-1:0]  raw,
    input logic [PLY_W-1:0]    ply,
    input logic [THRESH_W-1:0] thr,
    input logic                away
  );
    logic signed [SCORE_W:0] s;
    logic signed [SCORE_W:0] t;
    logic [SCORE_W-1:0]      p;
    logic [SCORE_W-1:0]      res;
    s   = {raw[SCORE_W-1], raw};
    t   = {2'b00, thr};
    p   = {{(SCORE_W-PLY_W){1'b0}}, ply};
    res = raw;
    if (s > t) begin
      res = away ? raw + p : raw - p;
    end else if (s < -t) begin
      res = away ? raw - p : raw + p;
    end
    return res;
  endfunction

  stt_req_t              req_q;
  logic [INDEX_BITS-1:0] cnt_q, cnt_d;
  logic [THRESH_W-1:0]   thr_q;
  logic [CUR_GEN_W-1:0]  gen_q;
  stt_rsp_t              rsp_q, rsp_d;
  logic                  done_q;

  logic                  ram_we;
  logic [INDEX_BITS-1:0] ram_waddr;
  logic [EntryW-1:0]     ram_wdata;
  logic [EntryW-1:0]     ram_rdata;
  entry_t                ent;
  entry_t                new_ent;
  logic [GEN_BITS-1:0]   gen_cur;
  logic                  replace;
  logic                  is_store;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      req_q <= req_i;
    end
    if (ctrl_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      thr_q  <= THRESH_RST;
      gen_q  <= CUR_GEN_RST;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= ctrl_i.exec;
      if (cfg_we_i && cfg_index_i == CFG_MATE_THRESHOLD) begin
        thr_q <= cfg_data_i[THRESH_W-1:0];
      end
      if (cfg_we_i && cfg_index_i == CFG_CURRENT_GENERATION) begin
        gen_q <= cfg_data_i[CUR_GEN_W-1:0];
      end
    end
  end

  assign cnt_d             = ctrl_i.clr_en ? cnt_q + INDEX_BITS'(1) : cnt_q;
  assign status_o.clr_last = &cnt_q;

  assign ent      = entry_t'(ram_rdata);
  assign gen_cur  = GEN_BITS'(gen_q);
  assign is_store = (req_q.action == ACT_STORE);
  assign replace  = (req_q.depth >= ent.depth) || (ent.gen != gen_cur);

  always_comb begin
    new_ent.key   = req_q.key;
    new_ent.score = mate_adjust(req_q.score, req_q.ply, thr_q, 1'b1);
    new_ent.move  = req_q.best_move;
    new_ent.depth = req_q.depth;
    new_ent.btype = req_q.bound_type;
    new_ent.gen   = gen_cur;
  end

  always_comb begin
    rsp_d = '0;
    if (is_store) begin
      rsp_d.written = replace;
    end else if (ent.depth != '0 && ent.key == req_q.key) begin
      rsp_d.hit         = 1'b1;
      rsp_d.found_score = mate_adjust(ent.score, req_q.ply, thr_q, 1'b0);
      rsp_d.found_depth = ent.depth;
      rsp_d.found_move  = ent.move;
      rsp_d.found_type  = ent.btype;
    end
  end

  assign ram_we    = ctrl_i.clr_en || (ctrl_i.exec && is_store && replace);
  assign ram_waddr = ctrl_i.clr_en ? cnt_q : req_q.key[INDEX_BITS-1:0];
  assign ram_wdata = ctrl_i.clr_en ? '0 : EntryW'(new_ent);

  stt_ram #(
    .WIDTH(EntryW),
    .DEPTH(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ctrl_i.accept),
    .raddr_i(req_i.key[INDEX_BITS-1:0]),
    .rdata_o(ram_rdata)
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_done_follows_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(ctrl_i.exec))
    else $error("Result beat without an execute step.");

  a_written_only_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.written) |-> (req_q.action == ACT_STORE) && !rsp_q.hit)
    else $error("Written flag on a probe.");

  a_hit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.hit) |-> rsp_q.found_depth != '0)
    else $error("Hit reported on an empty entry.");
`endif

endmodule

>>> hdl/search_transposition_table.sv
// Result: a beat on done_o is registered from the execute step that follows the accept.
// Requests: a new request is taken only in idle, after the registered read of the entry
// RAM and the execute step that writes back have finished; busy is high meanwhile.
// Reset: a clearing pass zeroes all 2**INDEX_BITS entries of the table; busy is high
// meanwhile. The receiver cannot stall; configuration writes are always taken.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Search transposition table
// Direct-mapped table of search results with mate-score adjustment and aging.
// ----------------------------------------------------------------------------
module search_transposition_table
  import stt_pkg::*;
#(
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF,
  parameter int unsigned GEN_BITS   = GEN_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  stt_req_t              req_i,
  output logic                  done_o,
  output stt_rsp_t              rsp_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  stt_ctrl_t   ctrl;
  stt_status_t status;

  assign cfg_ready_o = 1'b1;

  stt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .status_i(status),
    .ctrl_o  (ctrl)
  );

  stt_datapath #(
    .INDEX_BITS(INDEX_BITS),
    .GEN_BITS  (GEN_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .status_o   (status),
    .req_i      (req_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

endmodule
